>>> hdl/rgb_curve_smoothstep_mapper_core_assert.svh
// Assertion macros used by the tone curve mapper checker.
`ifndef RGB_CURVE_SMOOTHSTEP_MAPPER_CORE_ASSERT_SVH
`define RGB_CURVE_SMOOTHSTEP_MAPPER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define RCSM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define RCSM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/rcsm_pkg.sv
// Shared types and constants of the tone curve mapper.
`default_nettype none
package rcsm_pkg;

   localparam int FRAC_BITS = 16;
   localparam int PT_W      = FRAC_BITS + 1;
   localparam int DIV_STEPS = FRAC_BITS + 1;
   localparam logic [PT_W:0] THREE_ONE = (PT_W + 1)'(3 * (1 << FRAC_BITS));

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   localparam logic [1:0] REG_MASTER = 2'd0;
   localparam logic [1:0] REG_RED    = 2'd1;
   localparam logic [1:0] REG_GREEN  = 2'd2;
   localparam logic [1:0] REG_BLUE   = 2'd3;

   typedef enum logic [3:0] {
      LANE_IDLE,
      LANE_EVAL,
      LANE_LAST,
      LANE_FIRST,
      LANE_SCAN,
      LANE_DIV,
      LANE_SQUARE,
      LANE_SHAPE,
      LANE_BLEND,
      LANE_DONE
   } lane_state_type;

   typedef struct packed {
      logic       done;
      logic [7:0] value;
   } lane_result_type;

endpackage
`default_nettype wire

>>> hdl/rgb_curve_smoothstep_mapper_core.sv
// Pixel item time is set by the per-lane point scan (one point per cycle through the
// table RAM) and the 17-step shift-subtract divider; the three lanes run together.
// Load items do not block the input; one pixel is in flight at a time, a done result
// waits in the output register while the next item is taken.
// Reset clears the point counts (all curves identity); point tables are not cleared.
`default_nettype none
module rgb_curve_smoothstep_mapper_core
   import rcsm_pkg::*;
#(
   parameter int MAX_POINTS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_command,
   input  wire logic [1:0]  req_curve_select,
   input  wire logic [3:0]  req_point_slot,
   input  wire logic [16:0] req_point_x,
   input  wire logic [16:0] req_point_y,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   input  wire logic [7:0]  req_alpha_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   output logic [7:0]       rsp_alpha_out,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int AW = $clog2(4 * MAX_POINTS);

   logic [4:0]        cnt_ff [4];
   logic [4:0]        cnt_in [4];
   logic [NW-1:0]     n_clamp [4];
   logic              accept, pix_start, wr_en, ack, busy;
   logic [AW-1:0]     wr_addr;
   logic [2*PT_W-1:0] wr_data;
   logic [7:0]        chan [3];
   lane_result_type   lane_res [3];

   assign pready    = 1'b1;
   assign prdata    = 32'(cnt_ff[paddr[3:2]]);
   assign req_stall = busy;
   assign accept    = req_valid && !req_stall;
   assign pix_start = accept && (req_command == CMD_PIXEL);
   // drop loads aimed past the table
   assign wr_en     = accept && (req_command == CMD_LOAD)
                      && (32'(req_point_slot) < MAX_POINTS);
   assign wr_addr   = AW'(32'(req_curve_select) * MAX_POINTS + 32'(req_point_slot));
   assign wr_data   = {req_point_x, req_point_y};
   assign chan[0]   = req_red_in;
   assign chan[1]   = req_green_in;
   assign chan[2]   = req_blue_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      if (psel && penable && pwrite && pready) begin
         case (paddr[3:2])
            REG_MASTER: cnt_in[REG_MASTER] = pwdata[4:0];
            REG_RED:    cnt_in[REG_RED]    = pwdata[4:0];
            REG_GREEN:  cnt_in[REG_GREEN]  = pwdata[4:0];
            REG_BLUE:   cnt_in[REG_BLUE]   = pwdata[4:0];
            default: begin
            end
         endcase
      end
      for (int i = 0; i < 4; i++) begin
         n_clamp[i] = (32'(cnt_ff[i]) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(cnt_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < 4; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      rcsm_lane #(.MAX_POINTS(MAX_POINTS), .OWN_CURVE(g + 1)) u_lane (
         .clock    (clock),
         .reset    (reset),
         .start    (pix_start),
         .chan_in  (chan[g]),
         .master_n (n_clamp[0]),
         .own_n    (n_clamp[g + 1]),
         .wr_en    (wr_en),
         .wr_addr  (wr_addr),
         .wr_data  (wr_data),
         .ack      (ack),
         .result   (lane_res[g])
      );
   end

   rcsm_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .pix_start     (pix_start),
      .alpha_in      (req_alpha_in),
      .lane_res      (lane_res),
      .ack           (ack),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_alpha_out (rsp_alpha_out)
   );

endmodule
`default_nettype wire

>>> hdl/rcsm_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module rcsm_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hdl/rcsm_lane.sv
// One colour lane: master curve then own curve, with its own copy of the point tables.
`default_nettype none
module rcsm_lane
   import rcsm_pkg::*;
#(
   parameter int MAX_POINTS = 16,
   parameter int OWN_CURVE  = 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [7:0]                        chan_in,
   input  wire logic [$clog2(MAX_POINTS+1)-1:0]   master_n,
   input  wire logic [$clog2(MAX_POINTS+1)-1:0]   own_n,
   input  wire logic                              wr_en,
   input  wire logic [$clog2(4*MAX_POINTS)-1:0]   wr_addr,
   input  wire logic [2*PT_W-1:0]                 wr_data,
   input  wire logic                              ack,
   output lane_result_type                        result
);

   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int IW = $clog2(MAX_POINTS);
   localparam int AW = $clog2(4 * MAX_POINTS);
   localparam logic [AW-1:0] OWN_BASE = AW'(OWN_CURVE * MAX_POINTS);

   lane_state_type    state_ff, state_in;
   logic              phase_ff, phase_in;
   logic [PT_W-1:0]   x_ff, x_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [PT_W-1:0]   xa_ff, xa_in, ya_ff, ya_in;
   logic [PT_W-1:0]   xl_ff, xl_in, yl_ff, yl_in;
   logic [PT_W-1:0]   yb_ff, yb_in;
   logic [PT_W-1:0]   dv_ff, dv_in;
   logic [PT_W:0]     rem_ff, rem_in;
   logic [PT_W-1:0]   quo_ff, quo_in;
   logic [4:0]        step_ff, step_in;
   logic [PT_W-1:0]   t2_ff, t2_in, s_ff, s_in;
   logic [7:0]        out_ff, out_in;

   logic [NW-1:0]     n;
   logic [IW-1:0]     rd_idx;
   logic [AW-1:0]     rd_addr;
   logic [2*PT_W-1:0] rd_data;
   logic [PT_W-1:0]   rd_x, rd_y;
   logic              res_valid;
   logic [PT_W-1:0]   res_val;
   logic [PT_W:0]     rem_sh;
   logic              ge;
   logic [PT_W-1:0]   mul_a;
   logic [PT_W:0]     mul_b;
   logic [2*PT_W:0]   prod;
   logic [PT_W-1:0]   ydiff;
   logic              yneg;
   logic [PT_W+7:0]   scaled;

   rcsm_ram #(.WIDTH(2 * PT_W), .DEPTH(4 * MAX_POINTS)) u_pts (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_x    = rd_data[2*PT_W-1:PT_W];
   assign rd_y    = rd_data[PT_W-1:0];
   assign n       = phase_ff ? own_n : master_n;
   assign rd_addr = (phase_ff ? OWN_BASE : AW'(0)) + AW'(rd_idx);
   assign prod    = (2*PT_W+1)'(mul_a) * (2*PT_W+1)'(mul_b);
   assign yneg    = yb_ff < ya_ff;
   assign ydiff   = yneg ? (ya_ff - yb_ff) : (yb_ff - ya_ff);
   assign rem_sh  = (step_ff == 5'd0) ? rem_ff : {rem_ff[PT_W-1:0], 1'b0};
   assign ge      = rem_sh >= {1'b0, dv_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LANE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      phase_ff <= phase_in;
      x_ff     <= x_in;
      idx_ff   <= idx_in;
      xa_ff    <= xa_in;
      ya_ff    <= ya_in;
      xl_ff    <= xl_in;
      yl_ff    <= yl_in;
      yb_ff    <= yb_in;
      dv_ff    <= dv_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      t2_ff    <= t2_in;
      s_ff     <= s_in;
      out_ff   <= out_in;
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      x_in      = x_ff;
      idx_in    = idx_ff;
      xa_in     = xa_ff;
      ya_in     = ya_ff;
      xl_in     = xl_ff;
      yl_in     = yl_ff;
      yb_in     = yb_ff;
      dv_in     = dv_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      t2_in     = t2_ff;
      s_in      = s_ff;
      out_in    = out_ff;
      rd_idx    = '0;
      res_valid = 1'b0;
      res_val   = x_ff;
      mul_a     = quo_ff;
      mul_b     = (PT_W+1)'(quo_ff);
      scaled    = '0;

      case (state_ff)
         LANE_IDLE: begin
            if (start) begin
               // c * 65536 / 255 is c * 257, plus one at full scale
               x_in     = PT_W'({chan_in, chan_in}) + PT_W'(chan_in == 8'hFF);
               phase_in = 1'b0;
               state_in = LANE_EVAL;
            end
         end
         LANE_EVAL: begin
            rd_idx = IW'(n - NW'(1));
            if (n < NW'(2)) begin
               res_valid = 1'b1;
               res_val   = x_ff;
            end else begin
               state_in = LANE_LAST;
            end
         end
         LANE_LAST: begin
            rd_idx   = '0;
            xl_in    = rd_x;
            yl_in    = rd_y;
            state_in = LANE_FIRST;
         end
         LANE_FIRST: begin
            rd_idx = IW'(1);
            if (x_ff <= rd_x) begin
               res_valid = 1'b1;
               res_val   = rd_y;
            end else if (x_ff >= xl_ff) begin
               res_valid = 1'b1;
               res_val   = yl_ff;
            end else begin
               xa_in    = rd_x;
               ya_in    = rd_y;
               idx_in   = IW'(1);
               state_in = LANE_SCAN;
            end
         end
         LANE_SCAN: begin
            rd_idx = idx_ff + IW'(1);
            if (x_ff <= rd_x) begin
               yb_in = rd_y;
               if (rd_x <= xa_ff || x_ff < xa_ff) begin
                  res_valid = 1'b1;
                  res_val   = rd_y;
               end else begin
                  dv_in    = rd_x - xa_ff;
                  rem_in   = {1'b0, x_ff - xa_ff};
                  quo_in   = '0;
                  step_in  = '0;
                  state_in = LANE_DIV;
               end
            end else begin
               // advance to the next point
               xa_in  = rd_x;
               ya_in  = rd_y;
               idx_in = idx_ff + IW'(1);
            end
         end
         LANE_DIV: begin
            rem_in  = ge ? (rem_sh - {1'b0, dv_ff}) : rem_sh;
            quo_in  = {quo_ff[PT_W-2:0], ge};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(DIV_STEPS - 1)) begin
               state_in = LANE_SQUARE;
            end
         end
         LANE_SQUARE: begin
            mul_a    = quo_ff;
            mul_b    = (PT_W+1)'(quo_ff);
            t2_in    = prod[FRAC_BITS+PT_W-1:FRAC_BITS];
            state_in = LANE_SHAPE;
         end
         LANE_SHAPE: begin
            mul_a    = t2_ff;
            mul_b    = THREE_ONE - {quo_ff, 1'b0};
            s_in     = prod[FRAC_BITS+PT_W-1:FRAC_BITS];
            state_in = LANE_BLEND;
         end
         LANE_BLEND: begin
            mul_a     = s_ff;
            mul_b     = (PT_W+1)'(ydiff);
            res_valid = 1'b1;
            res_val   = yneg ? (ya_ff - prod[FRAC_BITS+PT_W-1:FRAC_BITS])
                             : (ya_ff + prod[FRAC_BITS+PT_W-1:FRAC_BITS]);
         end
         LANE_DONE: begin
            if (ack) begin
               state_in = LANE_IDLE;
            end
         end
         default: begin
            state_in = LANE_IDLE;
         end
      endcase

      if (res_valid) begin
         if (!phase_ff) begin
            x_in     = res_val;
            phase_in = 1'b1;
            state_in = LANE_EVAL;
         end else begin
            scaled   = {res_val, 8'd0} - (PT_W+8)'(res_val);
            out_in   = (scaled[PT_W+7:FRAC_BITS] > (PT_W+8-FRAC_BITS)'(255))
                       ? 8'hFF : scaled[FRAC_BITS+7:FRAC_BITS];
            state_in = LANE_DONE;
         end
      end
   end

   assign result.done  = (state_ff == LANE_DONE);
   assign result.value = out_ff;

endmodule
`default_nettype wire

>>> hdl/rcsm_merge.sv
// Merge stage: collects the three lane results and alpha into the result register.
`default_nettype none
module rcsm_merge
   import rcsm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            pix_start,
   input  wire logic [7:0]      alpha_in,
   input  wire lane_result_type lane_res [3],
   output logic                 ack,
   output logic                 busy,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic [7:0]           rsp_red_out,
   output logic [7:0]           rsp_green_out,
   output logic [7:0]           rsp_blue_out,
   output logic [7:0]           rsp_alpha_out
);

   logic       busy_ff, busy_in;
   logic       valid_ff, valid_in;
   logic [7:0] alpha_ff, alpha_nx;
   logic [7:0] red_ff, green_ff, blue_ff, aout_ff;
   logic       all_done;

   assign all_done = lane_res[0].done && lane_res[1].done && lane_res[2].done;
   assign ack      = busy_ff && all_done && (!valid_ff || !rsp_stall);

   always_comb begin
      busy_in  = busy_ff;
      valid_in = valid_ff;
      alpha_nx = alpha_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (ack) begin
         busy_in  = 1'b0;
         valid_in = 1'b1;
      end
      if (pix_start) begin
         busy_in  = 1'b1;
         alpha_nx = alpha_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      alpha_ff <= alpha_nx;
      if (ack) begin
         red_ff   <= lane_res[0].value;
         green_ff <= lane_res[1].value;
         blue_ff  <= lane_res[2].value;
         aout_ff  <= alpha_ff;
      end
   end

   assign busy          = busy_ff;
   assign rsp_valid     = valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_alpha_out = aout_ff;

endmodule
`default_nettype wire

>>> hdl/rcsm_checker.sv
// Port-level checker for the tone curve mapper, bound to the top level.
`default_nettype none
`include "rgb_curve_smoothstep_mapper_core_assert.svh"
module rcsm_checker
   import rcsm_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_command,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        pready
);

   `RCSM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result beat dropped while stalled")
   `RCSM_ASSERT_SAME(a_pready, 1'b1, pready, "pready low")
   `RCSM_ASSERT_NEXT(a_pix_busy, req_valid && !req_stall && req_command == CMD_PIXEL, req_stall, "pixel beat did not block the input")
   `RCSM_ASSERT_SAME(a_rsp_frees, $rose(rsp_valid), !req_stall, "result appeared with input still blocked")
   `RCSM_ASSERT_NEXT(a_load_quiet, req_valid && !req_stall && req_command == CMD_LOAD && !rsp_valid, !rsp_valid, "load beat produced a result")

endmodule

bind rgb_curve_smoothstep_mapper_core rcsm_checker u_rcsm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_command (req_command),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .pready      (pready)
);
`default_nettype wire
